// ===== rtl/chbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// chbd_pkg
// Shared types and constants for the canonical Huffman byte decoder.
// ============================================================================
package chbd_pkg;

    localparam int CODE_W  = 16;  // accumulator and first-code width
    localparam int SYM_W   = 8;   // symbol, count and base width
    localparam int DEPTH_W = 6;   // width of the depth field on a load word
    localparam int BYTE_W  = 8;   // bits per data byte
    localparam int BIT_W   = 3;   // bit position counter inside one byte

    // Word action codes
    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_DECODE = 1'b1;

    // One row of the code table, one row per code length
    typedef struct packed {
        logic [SYM_W-1:0]  count;
        logic [SYM_W-1:0]  base;
        logic [CODE_W-1:0] first;
    } entry_t;

endpackage : chbd_pkg
`default_nettype wire

// ===== rtl/canonical_huffman_byte_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// canonical_huffman_byte_decoder
// Loads a canonical Huffman table one code length at a time and decodes
// compressed bytes bit by bit into byte symbols.
// ============================================================================
//
//  Channel  Dir  Handshake          Word contents
//  -------  ---  -----------------  ---------------------------------------
//  s_       in   s_valid / s_ready  action, depth, symbol_count,
//                                   base_symbol, data_byte, record_end
//  m_       out  m_valid / m_ready  symbol, last
//
//  A decode word is worked one bit at a time: each bit needs one read of
//  the per-length table memory, and the next read address follows from
//  the match found on the current bit. A load word writes one table row.
//  The next word is taken in the cycle that consumes the last bit.
//  Reset (aresetn low, synchronous) clears control state and the per-length
//  valid bits; the table memory itself is not cleared, an invalid row reads
//  as an empty length. A stalled m_ side blocks the bit engine only when a
//  new symbol finds both the holding and the output register full.
// ============================================================================
module canonical_huffman_byte_decoder
    import chbd_pkg::*;
#(
    parameter int CODE_CAPACITY   = 4096,
    parameter int MAX_CODE_LENGTH = 20
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_action,
    input  wire  [DEPTH_W-1:0] s_depth,
    input  wire  [SYM_W-1:0]   s_symbol_count,
    input  wire  [SYM_W-1:0]   s_base_symbol,
    input  wire  [BYTE_W-1:0]  s_data_byte,
    input  wire                s_record_end,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [SYM_W-1:0]   m_symbol,
    output logic               m_last
);

    localparam int NUM_DEPTHS = MAX_CODE_LENGTH + 1;
    localparam int IDX_W      = $clog2(NUM_DEPTHS);
    localparam int ENT_W      = $clog2(CODE_CAPACITY + 1);
    localparam int CMP_W      = (ENT_W > SYM_W) ? ENT_W : SYM_W;

    localparam logic [IDX_W-1:0]   LEN_MAX   = IDX_W'(MAX_CODE_LENGTH);
    localparam logic [DEPTH_W:0]   DEPTH_TOP = (DEPTH_W + 1)'(NUM_DEPTHS);
    localparam logic [CMP_W-1:0]   ENT_LIMIT = CMP_W'(CODE_CAPACITY);
    localparam logic [BIT_W-1:0]   BIT_LAST  = BIT_W'(BYTE_W - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    entry_t                mem [NUM_DEPTHS];   // per-length table
    entry_t                rd_reg;             // registered read of row len_reg
    logic [NUM_DEPTHS-1:0] valid_reg, valid_next;

    logic [ENT_W-1:0]  entries_reg, entries_next;
    logic [CODE_W-1:0] nfc_reg, nfc_next;
    logic [CODE_W-1:0] acc_reg, acc_next;
    logic [IDX_W-1:0]  len_reg, len_next;

    logic              busy_reg, busy_next;
    logic [BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              rec_end_reg, rec_end_next;

    logic              pend_valid_reg, pend_valid_next;
    logic              pend_final_reg, pend_final_next;
    logic [SYM_W-1:0]  pend_sym_reg, pend_sym_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;
    logic [SYM_W-1:0]  out_sym_reg, out_sym_next;

    // ------------------------------------------------------------------
    // Bit engine: match on the current bit
    // ------------------------------------------------------------------
    logic [CODE_W-1:0] acc_shift;
    logic [CODE_W-1:0] offset;
    logic [SYM_W-1:0]  count_eff;
    logic              match;
    logic              out_free;
    logic              step;
    logic              last_bit;
    logic              pend_out;
    logic              accept;

    assign acc_shift = {acc_reg[CODE_W-2:0], shift_reg[BYTE_W-1]};
    assign offset    = acc_shift - rd_reg.first;
    // An unloaded length reads as empty
    assign count_eff = valid_reg[len_reg] ? rd_reg.count : '0;
    assign match     = busy_reg && (offset < {{(CODE_W - SYM_W){1'b0}}, count_eff});
    assign last_bit  = (bit_cnt_reg == BIT_LAST);

    assign out_free  = !out_valid_reg || m_ready;
    // Hold the bit when a new symbol has nowhere to go
    assign step      = busy_reg && (!match || !pend_valid_reg || out_free);
    assign pend_out  = pend_valid_reg && out_free && (pend_final_reg || (step && match));

    assign s_ready   = !busy_reg || (step && last_bit);
    assign accept    = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Table load
    // ------------------------------------------------------------------
    logic              wr_en;
    logic              new_table;
    logic [IDX_W-1:0]  wr_idx;
    entry_t            wr_data;
    logic [ENT_W-1:0]  ent_base;
    logic [CODE_W-1:0] nfc_base;
    logic [CMP_W-1:0]  room;
    logic [CMP_W-1:0]  count_ext;
    logic [SYM_W-1:0]  count_clip;
    logic [CMP_W-1:0]  ent_sum;

    assign wr_en     = accept && (s_action == ACTION_LOAD) && (s_depth != '0)
                       && ({1'b0, s_depth} <= DEPTH_TOP);
    assign new_table = (s_depth == DEPTH_W'(1));
    assign wr_idx    = IDX_W'(s_depth - DEPTH_W'(1));
    // A new table starts from zero codes and zero entries
    assign ent_base  = new_table ? '0 : entries_reg;
    assign nfc_base  = new_table ? '0 : nfc_reg;
    assign room      = ENT_LIMIT - CMP_W'(ent_base);
    assign count_ext = CMP_W'(s_symbol_count);
    assign count_clip = (count_ext > room) ? SYM_W'(room) : s_symbol_count;
    assign ent_sum   = CMP_W'(ent_base) + CMP_W'(count_clip);

    always_comb begin
        wr_data.count = count_clip;
        wr_data.base  = s_base_symbol;
        wr_data.first = nfc_base;
    end

    always_comb begin
        valid_next   = valid_reg;
        entries_next = entries_reg;
        nfc_next     = nfc_reg;
        if (wr_en) begin
            if (new_table) begin
                valid_next = '0;
            end
            valid_next[wr_idx] = 1'b1;
            entries_next       = ENT_W'(ent_sum);
            nfc_next           = (nfc_base + CODE_W'(count_clip)) << 1;
        end
    end

    // ------------------------------------------------------------------
    // Decode state
    // ------------------------------------------------------------------
    always_comb begin
        acc_next     = acc_reg;
        len_next     = len_reg;
        busy_next    = busy_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        rec_end_next = rec_end_reg;

        if (step) begin
            shift_next   = {shift_reg[BYTE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + BIT_W'(1);
            // Drop the code on a match, on overlong codes and at record end
            if (match || (len_reg == LEN_MAX) || (last_bit && rec_end_reg)) begin
                acc_next = '0;
                len_next = '0;
            end else begin
                acc_next = acc_shift;
                len_next = len_reg + IDX_W'(1);
            end
            if (last_bit) begin
                busy_next = 1'b0;
            end
        end

        if (accept && (s_action == ACTION_DECODE)) begin
            busy_next    = 1'b1;
            bit_cnt_next = '0;
            shift_next   = s_data_byte;
            rec_end_next = s_record_end;
        end
    end

    // ------------------------------------------------------------------
    // Holding register: a symbol waits until its last flag is known
    // ------------------------------------------------------------------
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_final_next = pend_final_reg;
        pend_sym_next   = pend_sym_reg;
        if (pend_out) begin
            pend_valid_next = 1'b0;
        end
        if (step && match) begin
            pend_valid_next = 1'b1;
            pend_final_next = 1'b0;
            pend_sym_next   = rd_reg.base + offset[SYM_W-1:0];
        end
        if (step && last_bit) begin
            pend_final_next = 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_sym_next   = out_sym_reg;
        if (out_free) begin
            out_valid_next = pend_out;
            out_last_next  = pend_final_reg;
            out_sym_next   = pend_sym_reg;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_symbol = out_sym_reg;
    assign m_last   = out_last_reg;

    // ------------------------------------------------------------------
    // Table memory: read the row for the next bit, forward a same-cycle write
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (wr_en && (wr_idx == len_next)) begin
            rd_reg <= wr_data;
        end else begin
            rd_reg <= mem[len_next];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            entries_reg    <= '0;
            nfc_reg        <= '0;
            acc_reg        <= '0;
            len_reg        <= '0;
            busy_reg       <= 1'b0;
            bit_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            entries_reg    <= entries_next;
            nfc_reg        <= nfc_next;
            acc_reg        <= acc_next;
            len_reg        <= len_next;
            busy_reg       <= busy_next;
            bit_cnt_reg    <= bit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            pend_final_reg <= pend_final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        rec_end_reg  <= rec_end_next;
        pend_sym_reg <= pend_sym_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_len_range : assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("code length beyond the table");

    a_entries_cap : assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(entries_reg) <= ENT_LIMIT)
        else $error("entry count beyond the limit");

    a_accept_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && busy_reg) |-> (last_bit && step))
        else $error("word taken before the last bit");

    a_match_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        (step && match) |=> (len_reg == '0 && acc_reg == '0 && pend_valid_reg))
        else $error("code not dropped after a match");

    a_pend_open : assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !pend_final_reg) |-> busy_reg)
        else $error("open symbol held with no byte in flight");

endmodule : canonical_huffman_byte_decoder
`default_nettype wire

// ===== sim/tb_canonical_huffman_byte_decoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_canonical_huffman_byte_decoder
// Self-checking bench: loads canonical Huffman tables and streams data bytes,
// predicting every decoded symbol with an in-bench table and bit decoder.
// ============================================================================
module tb_canonical_huffman_byte_decoder
    import chbd_pkg::*;
();

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int CODE_CAPACITY  = 4096;
    localparam int MAX_CODE_LEN   = 20;
    localparam int NUM_LENGTHS    = MAX_CODE_LEN + 1;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any accepted word
    localparam int DRAIN_CYCLES   = 40;    // drain time after the last owed symbol
    localparam int RANDOM_TARGET  = 360;   // counted words before the steady stream

    // One decoded symbol as seen on the m_ channel
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } sym_word_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_action       = ACTION_LOAD;
    logic [DEPTH_W-1:0] s_depth        = '0;
    logic [SYM_W-1:0]   s_symbol_count = '0;
    logic [SYM_W-1:0]   s_base_symbol  = '0;
    logic [BYTE_W-1:0]  s_data_byte    = '0;
    logic               s_record_end   = 1'b0;
    logic               m_ready        = 1'b0;
    wire                s_ready;
    wire                m_valid;
    wire  [SYM_W-1:0]   m_symbol;
    wire                m_last;

    canonical_huffman_byte_decoder #(
        .CODE_CAPACITY  (CODE_CAPACITY),
        .MAX_CODE_LENGTH(MAX_CODE_LEN)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_depth       (s_depth),
        .s_symbol_count(s_symbol_count),
        .s_base_symbol (s_base_symbol),
        .s_data_byte   (s_data_byte),
        .s_record_end  (s_record_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_last        (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Decoder shadow: code table per length plus the running bit accumulator
    // ------------------------------------------------------------------------
    logic [SYM_W-1:0]  len_count [1:NUM_LENGTHS];
    logic [SYM_W-1:0]  len_base  [1:NUM_LENGTHS];
    logic [CODE_W-1:0] len_first [1:NUM_LENGTHS];
    logic [12:0]       codes_used;
    logic [CODE_W-1:0] next_code;
    logic [CODE_W-1:0] code_acc;
    logic [4:0]        code_len;

    sym_word_t sym_expect_q[$];   // symbols still owed by the block, oldest first
    sym_word_t want;
    int        mismatch_cnt = 0;
    int        work_items   = 0;  // words that load a length or decode a byte
    int        idle_cycles  = 0;
    int        ready_hold   = 0;
    bit        bursty       = 1'b1;

    function automatic void clear_shadow();
        for (int d = 1; d <= NUM_LENGTHS; d++) begin
            len_count[d] = '0;
            len_base[d]  = '0;
            len_first[d] = '0;
        end
        codes_used = '0;
        next_code  = '0;
        code_acc   = '0;
        code_len   = '0;
    endfunction

    // Apply one length entry; out-of-range lengths leave the table untouched
    function automatic void apply_length_load(input logic [DEPTH_W-1:0] dep,
                                              input logic [SYM_W-1:0]   cnt,
                                              input logic [SYM_W-1:0]   base);
        int room;
        int kept;
        if (dep == 0 || dep > NUM_LENGTHS)
            return;
        // length 1 opens a new table: drop all counts and restart the codes
        if (dep == 1) begin
            for (int d = 1; d <= NUM_LENGTHS; d++)
                len_count[d] = '0;
            codes_used = '0;
            next_code  = '0;
        end
        room = CODE_CAPACITY - int'(codes_used);
        kept = (int'(cnt) > room) ? room : int'(cnt);
        len_count[dep] = SYM_W'(kept);
        len_base[dep]  = base;
        len_first[dep] = next_code;
        codes_used     = codes_used + 13'(kept);
        next_code      = (next_code + CODE_W'(kept)) << 1;
    endfunction

    // Shift one byte in MSB first and queue every symbol it completes
    function automatic void decode_byte_bits(input logic [BYTE_W-1:0] dbyte,
                                             input logic              rend);
        logic [CODE_W-1:0] ofs;
        logic [SYM_W-1:0]  sym_buf[8];
        int                n;
        n = 0;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            code_acc = {code_acc[CODE_W-2:0], dbyte[b]};
            code_len = code_len + 5'd1;
            if (code_len >= 1 && code_len <= NUM_LENGTHS) begin
                ofs = code_acc - len_first[code_len];
                if (ofs < CODE_W'(len_count[code_len])) begin
                    sym_buf[n] = len_base[code_len] + ofs[SYM_W-1:0];
                    n++;
                    code_acc = '0;
                    code_len = '0;
                end
            end
            // code too long: throw the bits away
            if (code_len > MAX_CODE_LEN) begin
                code_acc = '0;
                code_len = '0;
            end
        end
        for (int k = 0; k < n; k++)
            sym_expect_q.push_back({sym_buf[k], k == n - 1});
        if (rend) begin
            code_acc = '0;
            code_len = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Word sender: optional gap, present the word, hold until accepted.
    // s_valid is left high so a following word goes out back to back.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic               act,
                             input logic [DEPTH_W-1:0] dep,
                             input logic [SYM_W-1:0]   cnt,
                             input logic [SYM_W-1:0]   base,
                             input logic [BYTE_W-1:0]  dbyte,
                             input logic               rend);
        int gap;
        if (bursty && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_depth        <= dep;
        s_symbol_count <= cnt;
        s_base_symbol  <= base;
        s_data_byte    <= dbyte;
        s_record_end   <= rend;
        do @(posedge aclk); while (!s_ready);
        if (act == ACTION_LOAD) begin
            apply_length_load(dep, cnt, base);
            if (dep >= 1 && dep <= NUM_LENGTHS)
                work_items++;
        end else begin
            decode_byte_bits(dbyte, rend);
            work_items++;
        end
    endtask

    // Load word: data byte and record end are don't-care, so scramble them
    task automatic load_length(input int dep, input int cnt, input int base);
        send_word(ACTION_LOAD, DEPTH_W'(dep), SYM_W'(cnt), SYM_W'(base),
                  BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Decode word: table fields are don't-care, so scramble them
    task automatic decode_data(input int dbyte, input bit rend);
        send_word(ACTION_DECODE, DEPTH_W'($urandom_range(0, 63)),
                  SYM_W'($urandom_range(0, 255)), SYM_W'($urandom_range(0, 255)),
                  BYTE_W'(dbyte), rend);
    endtask

    // Canonical table: hand out the free codes at each length in turn
    task automatic load_code_table(input int top_len);
        int room;
        int cnt;
        int hi;
        room = 2;
        for (int d = 1; d <= top_len; d++) begin
            hi  = (room > 255) ? 255 : room;
            cnt = (d == top_len) ? hi : $urandom_range(0, hi);
            // leave out an empty length now and then (length 1 always goes)
            if (d == 1 || cnt != 0 || $urandom_range(0, 9) != 0)
                load_length(d, cnt, $urandom_range(0, 255));
            room = (room - cnt) * 2;
            if (room > (1 << 20))
                room = 1 << 20;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_table();
        decode_data(8'hFF, 1'b1);        // empty table: nothing decodes
        load_length(0, 255, 255);        // length zero: ignored
        load_length(1, 1, 8'h41);        // code 0
        load_length(63, 5, 9);           // every depth bit set: ignored
        load_length(22, 3, 1);           // one past the longest: ignored
        load_length(2, 1, 8'h42);        // code 10
        load_length(3, 2, 8'hFF);        // codes 110, 111: symbol wraps to 00
        decode_data(8'h00, 1'b0);        // eight symbols from one byte
        decode_data(8'hFF, 1'b0);        // two 3-bit codes, two bits left over
        decode_data(8'h5A, 1'b1);        // record end; the byte ends on a whole code
        load_length(1, 0, 0);            // new table
        load_length(4, 255, 8'h80);      // lengths 2 and 3 never loaded
        load_length(4, 3, 8'h10);        // reload length 4 at the current code
        decode_data(8'hAA, 1'b0);
        load_length(1, 0, 0);
        load_length(21, 1, 8'h07);       // single code of 21 zeros
        decode_data(8'h00, 1'b0);
        decode_data(8'h00, 1'b0);
        decode_data(8'h00, 1'b0);
        decode_data(8'hFF, 1'b0);        // no match up to the limit: discarded
        decode_data(8'hFF, 1'b0);
        decode_data(8'hFF, 1'b1);
        load_length(1, 255, 255);        // every single bit is a full code
        decode_data(8'h96, 1'b1);
    endtask

    task automatic test_entry_limit();
        load_length(1, 0, 0);
        // 17 full lengths overflow the table; the last one gets the remainder
        repeat (17) load_length(21, 255, $urandom_range(0, 255));
        repeat (3) load_length($urandom_range(2, 8), $urandom_range(1, 255),
                               $urandom_range(0, 255));
        repeat (10) decode_data($urandom_range(0, 255), $urandom_range(0, 3) == 0);
    endtask

    task automatic test_random_traffic(input int target);
        int pick;
        while (work_items < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                load_code_table(($urandom_range(0, 4) == 0) ? $urandom_range(9, 21)
                                                            : $urandom_range(1, 8));
                repeat ($urandom_range(4, 20))
                    decode_data($urandom_range(0, 255), $urandom_range(0, 4) == 0);
            end else if (pick == 7) begin
                // raw words with every field random
                repeat ($urandom_range(3, 8))
                    send_word(1'($urandom_range(0, 1)), DEPTH_W'($urandom_range(0, 63)),
                              SYM_W'($urandom_range(0, 255)),
                              SYM_W'($urandom_range(0, 255)),
                              BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(4, 12))
                    decode_data($urandom_range(0, 255), $urandom_range(0, 4) == 0);
            end
        end
    endtask

    task automatic test_steady_stream();
        bursty = 1'b0;
        load_code_table($urandom_range(1, 6));
        repeat (50) decode_data($urandom_range(0, 255), $urandom_range(0, 5) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_shadow();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_table();
        test_entry_limit();
        test_random_traffic(RANDOM_TARGET);
        test_steady_stream();
        s_valid <= 1'b0;
        while (sym_expect_q.size() != 0) @(posedge aclk);
        // give the bit engine time to show any stray symbol
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Result side: stall in random bursts, always ready in the final stretch
    always @(posedge aclk) begin
        if (!bursty) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= ($urandom_range(0, 2) != 0);
            ready_hold <= $urandom_range(0, 11);
        end
    end

    // Compare every accepted symbol against the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sym_expect_q.size() == 0) begin
                $display("%0t: unexpected word symbol=%h last=%b", $time, m_symbol, m_last);
                mismatch_cnt++;
            end else begin
                want = sym_expect_q.pop_front();
                if (m_symbol !== want.symbol) begin
                    $display("%0t: symbol expected %h actual %h", $time, want.symbol,
                             m_symbol);
                    mismatch_cnt++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, m_last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Hang detector: any accepted word on either side restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
